[rtl/pwmc_pkg.sv]
// ============================================================================
// PWM period and duty calculator package
// Shared widths, constants and the sequencer state type of the calculator.
// ============================================================================
`default_nettype none

package pwmc_pkg;

  // Field widths of the stream payloads and of the timer registers.
  localparam int unsigned ClkW  = 29;
  localparam int unsigned PscW  = 16;
  localparam int unsigned CmpW  = 17;
  localparam int unsigned ChW   = 2;
  localparam int unsigned DutyW = 8;
  localparam int unsigned PctW  = 7;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned InDataW      = 40;
  localparam int unsigned OutDataW     = 104;
  localparam int unsigned NumCmpFields = 4;

  // Shared divider: dividend, divisor and iteration counter widths.
  localparam int unsigned DvdW    = 34;
  localparam int unsigned DvsW    = 29;
  localparam int unsigned DivCntW = 6;
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DvdW - 1);

  // Multiplier operand width (reload plus one, or a compare value).
  localparam int unsigned MulW = 17;

  localparam logic [ClkW-1:0]  ClkResetHz = 29'd160000000;
  localparam logic [DvsW-1:0]  PscDivisor = 29'd65537;
  localparam logic [PctW-1:0]  DutyFull   = 7'd100;
  localparam logic [PscW-1:0]  HalfMax    = 16'hFFFF;
  localparam logic [DvdW-1:0]  TicksMax   = 34'd65536;

  localparam int unsigned NumChannelsDefault = 4;

  // Request kinds carried on the input tuser bit.
  localparam logic ReqSetFreq = 1'b0;
  localparam logic ReqSetDuty = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StFreqDiv1,
    StFreqDiv2,
    StFreqDiv3,
    StFreqDiv4,
    StRescaleMul,
    StRescaleDiv,
    StDutyMul,
    StDutyDiv,
    StOut
  } state_e;

endpackage

`default_nettype wire

[rtl/pwm_period_duty_calculator.sv]
// ============================================================================
// PWM period and duty calculator
// Keeps a 16-bit timer's prescaler, reload and compare values and updates
// them on set-frequency and set-duty requests with one shared divider.
// ============================================================================
//
// Each input transaction is one request and yields exactly one output
// transaction holding the prescaler, the reload and the four compare values
// after the request. All arithmetic runs through a single multiplier and a
// single restoring divider that retires one quotient bit per cycle, so the
// block takes one request at a time and deasserts s_axis_tready until the
// request's result has been loaded into the output register. A set-frequency
// request runs four divisions, then a multiply and a divide per channel when
// the old reload is nonzero; a set-duty request runs a multiply and a divide.
// The output register lets the next request be accepted while a result still
// waits for m_axis_tready. The timer clock register is written through the
// cfg port and must only be changed while no request is in flight.
`default_nettype none

module pwm_period_duty_calculator
  import pwmc_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Configuration write channel: timer clock frequency in hertz.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [ClkW-1:0]     cfg_data_i,

  // Request stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata from bit 0 up: freq_hz[28:0], channel[30:29], duty_percent[38:31],
  // zero pad[39].
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: req_type[0] (0 set frequency, 1 set duty).
  input  wire logic [0:0]          s_axis_tuser,

  // Result stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata from bit 0 up: prescaler[15:0], reload[31:16], compare_one[48:32],
  // compare_two[65:49], compare_three[82:66], compare_four[99:83],
  // zero pad[103:100].
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned ChIdxW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned NumShown  = (NUM_CHANNELS < NumCmpFields) ?
                                      NUM_CHANNELS : NumCmpFields;
  localparam logic [ChIdxW-1:0] LastIdx = ChIdxW'(NUM_CHANNELS - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;

  logic [ClkW-1:0]     clk_hz_q;
  logic [ClkW-1:0]     freq_q;
  logic [ChW-1:0]      ch_q;
  logic [PctW-1:0]     pct_q;

  logic [PscW-1:0]     prescaler_q;
  logic [PscW-1:0]     reload_q;
  logic [PscW-1:0]     old_reload_q;
  logic [PscW-1:0]     psc_new_q;
  logic [CmpW-1:0]     cmp_q [NUM_CHANNELS];
  logic [ChIdxW-1:0]   idx_q;

  // Restoring divider: remainder, shifting dividend/quotient, divisor.
  logic [DvsW-1:0]     div_rem_q;
  logic [DvdW-1:0]     div_quo_q;
  logic [DvsW-1:0]     div_den_q;
  logic [DivCntW-1:0]  div_cnt_q;
  logic                div_busy_q;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                in_accept;
  logic                out_load;
  logic                div_start;
  logic [DvdW-1:0]     div_dvd;
  logic [DvsW-1:0]     div_dvs;
  logic [MulW-1:0]     mul_a;
  logic [MulW-1:0]     mul_b;
  logic [2*MulW-1:0]   mul_prod;
  logic [CmpW-1:0]     cmp_sel;
  logic [PscW-1:0]     psc_cap;
  logic [PscW-1:0]     rel_new;
  logic [DvdW-1:0]     ticks_m1;
  logic [ClkW-1:0]     in_freq;
  logic [ChW-1:0]      in_ch;
  logic [DutyW-1:0]    in_duty;
  logic [DvsW:0]       div_trial;
  logic                div_bit;
  logic [CmpW-1:0]     cmp_out [NumCmpFields];

  assign in_freq = s_axis_tdata[ClkW-1:0];
  assign in_ch   = s_axis_tdata[ClkW+ChW-1:ClkW];
  assign in_duty = s_axis_tdata[ClkW+ChW+DutyW-1:ClkW+ChW];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Prescaler from the second division, capped to 16 bits.
  assign psc_cap = (div_quo_q > DvdW'(HalfMax)) ? HalfMax : div_quo_q[PscW-1:0];

  // Reload from the tick count: zero ticks count as one, clamp at the top.
  assign ticks_m1 = div_quo_q - DvdW'(1);
  always_comb begin
    if (div_quo_q == '0) begin
      rel_new = '0;
    end else if (div_quo_q > TicksMax) begin
      rel_new = HalfMax;
    end else begin
      rel_new = ticks_m1[PscW-1:0];
    end
  end

  // Compare value of the channel currently being rescaled.
  always_comb begin
    cmp_sel = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (idx_q == ChIdxW'(i)) begin
        cmp_sel = cmp_q[i];
      end
    end
  end

  // The single multiplier; its product is registered by the divider load.
  assign mul_a    = (state_q == StDutyMul) ? MulW'(pct_q) : cmp_sel;
  assign mul_b    = MulW'(reload_q) + MulW'(1);
  assign mul_prod = mul_a * mul_b;

  // One restoring division step.
  assign div_trial = {div_rem_q, div_quo_q[DvdW-1]};
  assign div_bit   = (div_trial >= {1'b0, div_den_q});

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = (s_axis_tuser[0] == ReqSetDuty) ? StDutyMul : StFreqDiv1;
        end
      end
      StFreqDiv1: begin
        if (!div_busy_q) state_d = StFreqDiv2;
      end
      StFreqDiv2: begin
        if (!div_busy_q) state_d = StFreqDiv3;
      end
      StFreqDiv3: begin
        if (!div_busy_q) state_d = StFreqDiv4;
      end
      StFreqDiv4: begin
        if (!div_busy_q) begin
          state_d = (reload_q != '0) ? StRescaleMul : StOut;
        end
      end
      StRescaleMul: state_d = StRescaleDiv;
      StRescaleDiv: begin
        if (!div_busy_q) begin
          state_d = (idx_q == LastIdx) ? StOut : StRescaleMul;
        end
      end
      StDutyMul: state_d = StDutyDiv;
      StDutyDiv: begin
        if (!div_busy_q) state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (divider launch and operand selection)
  // --------------------------------------------------------------------------
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = DvsW'(1);
    out_load  = (state_q == StOut) && (!out_valid_q || m_axis_tready);
    if (state_d != state_q) begin
      unique case (state_d)
        StFreqDiv1: begin
          // clk / 65537, then divided by f below, gives the prescaler.
          div_start = 1'b1;
          div_dvd   = DvdW'(clk_hz_q);
          div_dvs   = PscDivisor;
        end
        StFreqDiv2: begin
          div_start = 1'b1;
          div_dvd   = div_quo_q;
          div_dvs   = freq_q;
        end
        StFreqDiv3: begin
          // clk / (p + 1), then divided by f below, gives the tick count.
          div_start = 1'b1;
          div_dvd   = DvdW'(clk_hz_q);
          div_dvs   = DvsW'(psc_cap) + DvsW'(1);
        end
        StFreqDiv4: begin
          div_start = 1'b1;
          div_dvd   = div_quo_q;
          div_dvs   = freq_q;
        end
        StRescaleDiv: begin
          div_start = 1'b1;
          div_dvd   = mul_prod;
          div_dvs   = DvsW'(old_reload_q) + DvsW'(1);
        end
        StDutyDiv: begin
          div_start = 1'b1;
          div_dvd   = mul_prod;
          div_dvs   = DvsW'(DutyFull);
        end
        default: begin
          div_start = 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State, configuration and request capture
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      clk_hz_q <= ClkResetHz;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        clk_hz_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      freq_q <= (in_freq == '0) ? ClkW'(1) : in_freq;
      ch_q   <= in_ch;
      pct_q  <= (in_duty > DutyW'(DutyFull)) ? DutyFull : in_duty[PctW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Timer registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q  <= '0;
      reload_q     <= HalfMax;
      old_reload_q <= '0;
      psc_new_q    <= '0;
      idx_q        <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cmp_q[i] <= '0;
      end
    end else begin
      if (state_q == StFreqDiv2 && !div_busy_q) begin
        psc_new_q <= psc_cap;
      end
      if (state_q == StFreqDiv4 && !div_busy_q) begin
        prescaler_q  <= psc_new_q;
        reload_q     <= rel_new;
        old_reload_q <= reload_q;
        idx_q        <= '0;
      end
      if (state_q == StRescaleDiv && !div_busy_q) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (idx_q == ChIdxW'(i)) begin
            cmp_q[i] <= div_quo_q[CmpW-1:0];
          end
        end
        if (idx_q != LastIdx) begin
          idx_q <= idx_q + ChIdxW'(1);
        end
      end
      if (state_q == StDutyDiv && !div_busy_q) begin
        // A channel index beyond the implemented channels changes nothing.
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (int'(ch_q) == i) begin
            cmp_q[i] <= div_quo_q[CmpW-1:0];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared restoring divider, one quotient bit per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
      if (div_cnt_q == DivLastStep) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= div_dvd;
      div_den_q <= div_dvs;
    end else if (div_busy_q) begin
      div_rem_q <= div_bit ? DvsW'(div_trial - {1'b0, div_den_q}) : div_trial[DvsW-1:0];
      div_quo_q <= {div_quo_q[DvdW-2:0], div_bit};
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NumCmpFields; i++) begin
      cmp_out[i] = '0;
    end
    for (int i = 0; i < NumShown; i++) begin
      cmp_out[i] = cmp_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {4'b0000, cmp_out[3], cmp_out[2], cmp_out[1], cmp_out[0],
                     reload_q, prescaler_q};
    end
  end

endmodule

`default_nettype wire
